// File: hdl/rc4ke_pkg.sv
// package: constants, types and key derivation helpers for the rc4 candidate evaluator
`timescale 1ns / 1ps
package rc4ke_pkg;
	localparam int CandidateBytes = 7;
	localparam int PlainBytes = 10;
	localparam int KeyLen = 72;
	localparam int B64Chars = 36;
	localparam logic [7:0] PadValue = 8'h41;
	localparam logic [7:0] HiBias = 8'h78;
	localparam logic [7:0] LoBias = 8'h7a;

	localparam logic [1:0] REG_CIPHER_LOW = 2'd0;
	localparam logic [1:0] REG_CIPHER_HIGH = 2'd1;
	localparam logic [1:0] REG_TARGET_LOW = 2'd2;
	localparam logic [1:0] REG_TARGET_HIGH = 2'd3;

	// commands from controller to datapath
	typedef struct packed {
		logic load;      // capture candidate, clear indices
		logic init_wr;   // write identity at counter
		logic rd_i;      // read s[i]
		logic rd_j;      // read s[j] after j update
		logic wr_i;      // write s[j] old value to i
		logic wr_j;      // write s[i] old value to j
		logic rd_t;      // read s[s[i]+s[j]]
		logic ks_mode;   // keystream phase
		logic ks_init;   // keystream start: j to zero, i to one
		logic store_ks;  // xor keystream byte into plaintext
		logic score;     // step score over one byte
	} rc4ke_cmd_t;

	typedef struct packed {
		logic cnt_last;  // counter at end of its range
	} rc4ke_sts_t;

	// base64 alphabet lookup
	function automatic logic [7:0] b64_char(input logic [5:0] v);
		logic [7:0] c;
		if (v < 6'd26) c = 8'h41 + {2'b00, v};
		else if (v < 6'd52) c = 8'h61 + {2'b00, v} - 8'd26;
		else if (v < 6'd62) c = 8'h30 + {2'b00, v} - 8'd52;
		else if (v == 6'd62) c = 8'h2b;
		else c = 8'h2f;
		return c;
	endfunction

	// raw utf-16 byte at position p (0..26)
	function automatic logic [7:0] raw_byte(input logic [8*CandidateBytes-1:0] cand,
		input logic [4:0] p);
		logic [7:0] b;
		logic [3:0] e;
		logic [7:0] r;
		e = p[4:1];
		if (e[3:1] < CandidateBytes[2:0] && CandidateBytes < 8)
			b = cand[8*(CandidateBytes-1-int'(e[3:1])) +: 8];
		else if (CandidateBytes == 8)
			b = cand[8*(CandidateBytes-1-int'(e[3:1])) +: 8];
		else
			b = PadValue;
		if (p[0]) r = 8'h00;
		else if (e[0]) r = {4'h0, b[3:0]} + LoBias;
		else r = {4'h0, b[7:4]} + HiBias;
		return r;
	endfunction

	// key byte at position k (0..71)
	function automatic logic [7:0] key_byte(input logic [8*CandidateBytes-1:0] cand,
		input logic [6:0] k);
		logic [5:0] ci;
		logic [3:0] grp;
		logic [1:0] sel;
		logic [23:0] blk;
		logic [5:0] v;
		ci = k[6:1];
		grp = ci[5:2];
		sel = ci[1:0];
		blk = {raw_byte(cand, 5'(3*grp)), raw_byte(cand, 5'(3*grp+1)),
			raw_byte(cand, 5'(3*grp+2))};
		case (sel)
			2'd0: v = blk[23:18];
			2'd1: v = blk[17:12];
			2'd2: v = blk[11:6];
			default: v = blk[5:0];
		endcase
		return k[0] ? 8'h00 : b64_char(v);
	endfunction

	function automatic logic [7:0] fold_lower(input logic [7:0] v);
		return (v >= 8'h41 && v <= 8'h5a) ? v + 8'h20 : v;
	endfunction
endpackage

// File: hdl/rc4ke_if.sv
// valid/ready channel interfaces for candidate and result items
`timescale 1ns / 1ps
interface rc4ke_in_if;
	logic valid;
	logic ready;
	logic [55:0] candidate_bytes;
	modport source(output valid, output candidate_bytes, input ready);
	modport sink(input valid, input candidate_bytes, output ready);
endinterface

interface rc4ke_out_if;
	logic valid;
	logic ready;
	logic [63:0] plain_low;
	logic [15:0] plain_high;
	logic [3:0] match_length;
	logic [9:0] distance_first4;
	logic [10:0] distance_first6;
	logic [11:0] distance_all10;
	modport source(output valid, output plain_low, output plain_high, output match_length,
		output distance_first4, output distance_first6, output distance_all10, input ready);
	modport sink(input valid, input plain_low, input plain_high, input match_length,
		input distance_first4, input distance_first6, input distance_all10, output ready);
endinterface

// File: hdl/rc4ke_ram.sv
// generic single-port ram with registered read
`timescale 1ns / 1ps
module rc4ke_ram #(
	parameter int Width = 8,
	parameter int Depth = 256
) (
	input logic clk,
	input logic we,
	input logic [$clog2(Depth)-1:0] addr,
	input logic [Width-1:0] wdata,
	output logic [Width-1:0] rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) mem[addr] <= wdata;
		rdata <= mem[addr];
	end
endmodule

// File: hdl/rc4ke_datapath.sv
// datapath: permutation memory, key schedule and keystream indices, scoring
`timescale 1ns / 1ps
module rc4ke_datapath (
	input logic clk,
	input logic arst_n,
	input rc4ke_pkg::rc4ke_cmd_t cmd,
	output rc4ke_pkg::rc4ke_sts_t sts,
	input logic [55:0] candidate_bytes,
	input logic [79:0] cipher,
	input logic [79:0] target,
	output logic [79:0] plain,
	output logic [3:0] match_length,
	output logic [9:0] distance_first4,
	output logic [10:0] distance_first6,
	output logic [11:0] distance_all10
);
	import rc4ke_pkg::*;

	logic [55:0] cand_q;
	logic [7:0] i_q, j_q, si_q, sj_q;
	logic [6:0] kidx_q;
	logic [3:0] k_q;
	logic [7:0] addr, wdata, rdata, j_next, ks_byte, cb, pb, tb, diff;
	logic we, matching_q;
	logic [79:0] plain_q;
	logic [3:0] match_q;
	logic [9:0] d4_q;
	logic [10:0] d6_q;
	logic [11:0] d10_q;

	rc4ke_ram #(.Width(8), .Depth(256)) u_perm (
		.clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
	);

	// next j: schedule adds key byte, keystream does not
	assign j_next = cmd.ks_mode ? j_q + rdata : j_q + rdata + key_byte(cand_q, kidx_q);

	// memory address and write data select
	always_comb begin
		we = 1'b0;
		addr = i_q;
		wdata = i_q;
		if (cmd.init_wr) begin
			we = 1'b1;
		end else if (cmd.rd_i) begin
			addr = i_q;
		end else if (cmd.rd_j) begin
			addr = j_next;
		end else if (cmd.wr_i) begin
			// s[j] arrives on the read port this cycle
			we = 1'b1;
			wdata = rdata;
		end else if (cmd.wr_j) begin
			we = 1'b1;
			addr = j_q;
			wdata = si_q;
		end else if (cmd.rd_t) begin
			addr = si_q + sj_q;
		end
	end

	assign sts.cnt_last = cmd.ks_mode ? (k_q == 4'(PlainBytes - 1)) : (i_q == 8'hff);
	assign ks_byte = rdata;
	// plaintext byte is scored in the cycle it is formed
	assign cb = cipher[79 - 8*k_q -: 8];
	assign pb = cb ^ ks_byte;
	assign tb = target[79 - 8*k_q -: 8];
	assign diff = (pb > tb) ? pb - tb : tb - pb;

	// index and score registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cand_q <= '0;
			i_q <= '0;
			j_q <= '0;
			si_q <= '0;
			sj_q <= '0;
			k_q <= '0;
			kidx_q <= '0;
			matching_q <= 1'b1;
			plain_q <= '0;
			match_q <= '0;
			d4_q <= '0;
			d6_q <= '0;
			d10_q <= '0;
		end else begin
			if (cmd.load) begin
				cand_q <= candidate_bytes;
				i_q <= '0;
				j_q <= '0;
				k_q <= '0;
				kidx_q <= '0;
				matching_q <= 1'b1;
				plain_q <= '0;
				match_q <= '0;
				d4_q <= '0;
				d6_q <= '0;
				d10_q <= '0;
			end
			if (cmd.init_wr) i_q <= i_q + 8'd1;
			if (cmd.ks_init) begin
				i_q <= 8'd1;
				j_q <= '0;
			end
			if (cmd.rd_j) begin
				si_q <= rdata;
				j_q <= j_next;
			end
			if (cmd.wr_i) sj_q <= rdata;
			if (cmd.wr_j && !cmd.ks_mode) begin
				i_q <= i_q + 8'd1;
				kidx_q <= (kidx_q == 7'(KeyLen - 1)) ? 7'd0 : kidx_q + 7'd1;
			end
			if (cmd.store_ks) begin
				plain_q[79 - 8*k_q -: 8] <= pb;
				i_q <= i_q + 8'd1;
			end
			if (cmd.score) begin
				if (matching_q && fold_lower(pb) == fold_lower(tb)) match_q <= match_q + 4'd1;
				else matching_q <= 1'b0;
				if (k_q < 4'd4) d4_q <= d4_q + 10'(diff);
				if (k_q < 4'd6) d6_q <= d6_q + 11'(diff);
				d10_q <= d10_q + 12'(diff);
				k_q <= k_q + 4'd1;
			end
		end
	end

	assign plain = plain_q;
	assign match_length = match_q;
	assign distance_first4 = d4_q;
	assign distance_first6 = d6_q;
	assign distance_all10 = d10_q;
endmodule

// File: hdl/rc4ke_ctrl.sv
// controller: sequences init, key schedule, keystream and scoring
`timescale 1ns / 1ps
module rc4ke_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input logic out_ready,
	input rc4ke_pkg::rc4ke_sts_t sts,
	output rc4ke_pkg::rc4ke_cmd_t cmd
);
	import rc4ke_pkg::*;

	typedef enum logic [9:0] {
		S_IDLE   = 10'b0000000001,
		S_INIT   = 10'b0000000010,
		S_RDI    = 10'b0000000100,
		S_RDJ    = 10'b0000001000,
		S_WRI    = 10'b0000010000,
		S_WRJ    = 10'b0000100000,
		S_RDT    = 10'b0001000000,
		S_KS     = 10'b0010000000,
		S_SCORE  = 10'b0100000000,
		S_DONE   = 10'b1000000000
	} state_t;

	state_t state_q, state_d;
	logic ks_q, ks_d, last_q, last_d;

	assign in_ready = (state_q == S_IDLE);
	assign out_valid = (state_q == S_DONE);

	// next state and commands
	always_comb begin
		state_d = state_q;
		ks_d = ks_q;
		last_d = last_q;
		cmd = '0;
		cmd.ks_mode = ks_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					ks_d = 1'b0;
					state_d = S_INIT;
				end
			end
			S_INIT: begin
				cmd.init_wr = 1'b1;
				if (sts.cnt_last) state_d = S_RDI;
			end
			S_RDI: begin
				cmd.rd_i = 1'b1;
				last_d = sts.cnt_last;
				state_d = S_RDJ;
			end
			S_RDJ: begin
				cmd.rd_j = 1'b1;
				state_d = S_WRI;
			end
			S_WRI: begin
				cmd.wr_i = 1'b1;
				state_d = S_WRJ;
			end
			S_WRJ: begin
				cmd.wr_j = 1'b1;
				if (ks_q) state_d = S_RDT;
				else if (last_q) begin
					ks_d = 1'b1;
					state_d = S_KS;
				end else state_d = S_RDI;
			end
			S_KS: begin
				// keystream starts with j at zero and i at one
				cmd.ks_init = 1'b1;
				state_d = S_RDI;
			end
			S_RDT: begin
				cmd.rd_t = 1'b1;
				state_d = S_SCORE;
			end
			S_SCORE: begin
				// form the plaintext byte and score it in the same cycle
				cmd.store_ks = 1'b1;
				cmd.score = 1'b1;
				state_d = last_q ? S_DONE : S_RDI;
			end
			S_DONE: begin
				if (out_ready) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ks_q <= 1'b0;
			last_q <= 1'b0;
		end else begin
			state_q <= state_d;
			ks_q <= ks_d;
			last_q <= last_d;
		end
	end
endmodule

// File: hdl/rc4_candidate_key_evaluator_top.sv
// top level: config registers, controller and datapath of the rc4 candidate evaluator
// usage: one candidate item in on in_ch (valid/ready), one result item out on out_ch.
// config: write enable, index 0..3 and 64-bit data; write only while idle.
// each item: reload the identity permutation (S_INIT), run the key schedule swaps
// (S_RDI, S_RDJ, S_WRI, S_WRJ), set up the keystream indices (S_KS), then for each
// keystream byte S_RDI, S_RDJ, S_WRI, S_WRJ, S_RDT and S_SCORE, with xor and score in
// S_SCORE; the order is set by the single port of the permutation ram.
// one item is in flight at a time; in_ch.ready is high only while idle.
// out_ch.valid is high in S_DONE, entered after the last keystream byte is scored.
// when the receiver is ready, the result is held in S_DONE and the block then returns
// to S_IDLE to accept the next item.
// the result is held on out_ch until taken; while the receiver stalls the
// block waits in S_DONE and accepts no new item.
// reset restores the default ciphertext and target and returns the block to idle.
`timescale 1ns / 1ps
module rc4_candidate_key_evaluator_top (
	input logic clk,
	input logic arst_n,
	rc4ke_in_if.sink in_ch,
	rc4ke_out_if.source out_ch,
	input logic cfg_we,
	input logic [1:0] cfg_index,
	input logic [63:0] cfg_data
);
	import rc4ke_pkg::*;

	logic [63:0] cipher_low_q, target_low_q;
	logic [15:0] cipher_high_q, target_high_q;
	rc4ke_cmd_t cmd;
	rc4ke_sts_t sts;
	logic [79:0] plain;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cipher_low_q <= 64'h698b8fb18f3b4f99;
			cipher_high_q <= 16'h6172;
			target_low_q <= 64'h66006c0061006700;
			target_high_q <= 16'h7b00;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CIPHER_LOW: cipher_low_q <= cfg_data;
				REG_CIPHER_HIGH: cipher_high_q <= cfg_data[15:0];
				REG_TARGET_LOW: target_low_q <= cfg_data;
				REG_TARGET_HIGH: target_high_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	rc4ke_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.sts(sts), .cmd(cmd)
	);

	rc4ke_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.candidate_bytes(in_ch.candidate_bytes),
		.cipher({cipher_low_q, cipher_high_q}),
		.target({target_low_q, target_high_q}),
		.plain(plain),
		.match_length(out_ch.match_length),
		.distance_first4(out_ch.distance_first4),
		.distance_first6(out_ch.distance_first6),
		.distance_all10(out_ch.distance_all10)
	);

	assign out_ch.plain_low = plain[79:16];
	assign out_ch.plain_high = plain[15:0];
endmodule
